FILE: rtl/core/iwb_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and curve tables for the white balance block.
// No dependencies; all other files import this package.
package iwb_pkg;

  localparam int LIN_BITS     = 16;
  localparam int OUT_LUT_BITS = 12;
  localparam int FRAC         = 30;
  localparam int LIN_W        = LIN_BITS + 1;        // holds 1.0 exactly
  localparam int GAIN_W       = 32;
  localparam int PROD_W       = LIN_W + GAIN_W;
  localparam int IDX_W        = OUT_LUT_BITS + 1;
  localparam int THR_W        = FRAC + 1;
  localparam int CNT_W        = 5;
  localparam int ILL_W        = 16;
  localparam int PIX_W        = 8;
  localparam logic [GAIN_W-1:0] INV_SQRT3_Q32 = 32'd2479700525;
  localparam logic [ILL_W-1:0]  ILLUM_RST     = 16'd37837;

  localparam logic [1:0] REG_ILLUM_RED   = 2'd0;
  localparam logic [1:0] REG_ILLUM_GREEN = 2'd1;
  localparam logic [1:0] REG_ILLUM_BLUE  = 2'd2;

  localparam logic REQ_MEASURE = 1'b0;
  localparam logic REQ_CORRECT = 1'b1;

  typedef logic [LIN_W-1:0] lin_rom_t [256];
  typedef logic [THR_W-1:0] thr_rom_t [256];

  typedef struct packed {
    logic       meas;      // record pixel into running max
    logic       clr;       // restart max at this pixel
    logic       load;      // latch pixel
    logic       gain_ld;
    logic       gain_step;
    logic       mul_max;
    logic       mul_pix;
    logic       norm_ld;
    logic       norm_step;
    logic       enc_step;
    logic [2:0] enc_bit;
  } iwb_cmd_t;

  function automatic longint unsigned mulq(longint unsigned a, longint unsigned b);
    return (a * b) >> FRAC;
  endfunction

  // Linear value in Q1.30 of sRGB level n/510.
  function automatic longint unsigned decode_q30(int unsigned n);
    longint unsigned nn, t, t2, lo, hi, mid, p;
    nn = longint'(n);
    lo = 0;
    hi = 64'd1 << FRAC;
    if (n <= 20) begin
      return (nn * 100 << FRAC) / 658920;
    end
    t = ((nn * 1000 + 28050) << FRAC) / 538050;
    if (t > (64'd1 << FRAC)) t = 64'd1 << FRAC;
    t2 = mulq(t, t);
    // fifth root by bisection
    for (int i = 0; i < 40; i++) begin
      if (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        p = mulq(mid, mid);
        p = mulq(p, p);
        p = mulq(p, mid);
        if (p <= t2) lo = mid;
        else hi = mid - 1;
      end
    end
    return mulq(t2, lo);
  endfunction

  function automatic lin_rom_t build_lin();
    lin_rom_t r;
    longint unsigned l;
    for (int v = 0; v < 256; v++) begin
      l = decode_q30(2 * v);
      r[v] = LIN_W'((l + (64'd1 << (FRAC - LIN_BITS - 1))) >> (FRAC - LIN_BITS));
    end
    return r;
  endfunction

  function automatic thr_rom_t build_thr();
    thr_rom_t r;
    r[0] = '0;
    for (int v = 1; v < 256; v++) begin
      r[v] = THR_W'(decode_q30(2 * v - 1));
    end
    return r;
  endfunction

  localparam lin_rom_t LIN_ROM = build_lin();
  localparam thr_rom_t THR_ROM = build_thr();

endpackage

FILE: rtl/core/iwb_in_if.sv
`timescale 1ns / 1ps
// Pixel input channel: valid/ready plus request type and sRGB pixel.
// Depends on iwb_pkg.
interface iwb_in_if import iwb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [PIX_W-1:0] pix_red;
  logic [PIX_W-1:0] pix_green;
  logic [PIX_W-1:0] pix_blue;
  modport source (output valid, req_type, pix_red, pix_green, pix_blue, input ready);
  modport sink   (input valid, req_type, pix_red, pix_green, pix_blue, output ready);
endinterface

FILE: rtl/core/iwb_out_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready plus balanced sRGB pixel.
// Depends on iwb_pkg.
interface iwb_out_if import iwb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_red;
  logic [PIX_W-1:0] out_green;
  logic [PIX_W-1:0] out_blue;
  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

FILE: rtl/core/iwb_cfg_if.sv
`timescale 1ns / 1ps
// Register write channel: valid/ready, register index and data.
// Depends on iwb_pkg.
interface iwb_cfg_if import iwb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       index;
  logic [ILL_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/illuminant_white_balance_srgb.sv
`timescale 1ns / 1ps
// White balance top: config registers, sequencer, three channel lanes, max merge.
// Measure words leave the sequencer idle. A correct word runs each lane's 32-step
// gain divider (first correct word of a frame only), the gain multiplies, the max
// merge, the 13-step normalizing divider and the 8-step encode search per lane.
// One word in flight at a time. rst_n (synchronous, active low) clears the
// maxima, returns to the measure pass and loads the illuminant defaults.
module illuminant_white_balance_srgb import iwb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  iwb_in_if.sink    in_ch,
  iwb_out_if.source out_ch,
  iwb_cfg_if.sink   cfg_ch
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_GAIN  = 8'b0000_0010,
    ST_PMAX  = 8'b0000_0100,
    ST_MERGE = 8'b0000_1000,
    ST_PPIX  = 8'b0001_0000,
    ST_NLD   = 8'b0010_0000,
    ST_NORM  = 8'b0100_0000,
    ST_ENC   = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              corr_r, corr_nxt, done;
  logic [ILL_W-1:0]  ill_r [3];
  logic [PROD_W-1:0] m_r, prod [3], m01;
  logic [PIX_W-1:0]  code [3], pix [3];
  logic              oval_r;
  logic [PIX_W-1:0]  ored_r, ogrn_r, oblu_r;
  logic              acc;
  iwb_cmd_t          cmd;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ill_r[0] <= ILLUM_RST;
      ill_r[1] <= ILLUM_RST;
      ill_r[2] <= ILLUM_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_ILLUM_RED:   ill_r[0] <= cfg_ch.data;
        REG_ILLUM_GREEN: ill_r[1] <= cfg_ch.data;
        REG_ILLUM_BLUE:  ill_r[2] <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign acc  = in_ch.valid && in_ch.ready;
  assign done = (state_r == ST_ENC) && (cnt_r == CNT_W'(PIX_W - 1));
  assign pix[0] = in_ch.pix_red;
  assign pix[1] = in_ch.pix_green;
  assign pix[2] = in_ch.pix_blue;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    corr_nxt  = corr_r;
    cmd       = '0;
    cmd.load  = acc;
    cmd.enc_bit = ~cnt_r[2:0];
    unique case (state_r)
      ST_IDLE: begin
        if (acc && in_ch.req_type == REQ_MEASURE) begin
          cmd.meas = 1'b1;
          cmd.clr  = corr_r;
          corr_nxt = 1'b0;
        end else if (acc) begin
          corr_nxt = 1'b1;
          cnt_nxt  = '0;
          if (!corr_r) begin
            cmd.gain_ld = 1'b1;
            state_nxt   = ST_GAIN;
          end else begin
            state_nxt = ST_PMAX;
          end
        end
      end
      ST_GAIN: begin
        cmd.gain_step = 1'b1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(GAIN_W - 1)) state_nxt = ST_PMAX;
      end
      ST_PMAX: begin
        cmd.mul_max = 1'b1;
        state_nxt   = ST_MERGE;
      end
      ST_MERGE: state_nxt = ST_PPIX;
      ST_PPIX: begin
        cmd.mul_pix = 1'b1;
        state_nxt   = ST_NLD;
      end
      ST_NLD: begin
        cmd.norm_ld = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = ST_NORM;
      end
      ST_NORM: begin
        cmd.norm_step = 1'b1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(IDX_W - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_ENC;
        end
      end
      ST_ENC: begin
        // last step waits until the output register is free
        if (!done || !oval_r || out_ch.ready) begin
          cmd.enc_step = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
          if (done) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      corr_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      corr_r  <= corr_nxt;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    iwb_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd),
      .pix   (pix[c]),
      .illum (ill_r[c]),
      .m     (m_r),
      .prod  (prod[c]),
      .code  (code[c])
    );
  end

  // merge: frame scale is the largest gained channel maximum
  assign m01 = (prod[1] > prod[0]) ? prod[1] : prod[0];
  always_ff @(posedge clk) begin
    if (state_r == ST_MERGE) m_r <= (prod[2] > m01) ? prod[2] : m01;
  end

  // encode step is combinational on code, so capture after the final step lands
  logic fin_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_r  <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      fin_r <= done && cmd.enc_step;
      if (fin_r) oval_r <= 1'b1;
      else if (out_ch.ready) oval_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_r) begin
      ored_r <= (m_r == '0) ? '0 : code[0];
      ogrn_r <= (m_r == '0) ? '0 : code[1];
      oblu_r <= (m_r == '0) ? '0 : code[2];
    end
  end

  assign out_ch.valid     = oval_r;
  assign out_ch.out_red   = ored_r;
  assign out_ch.out_green = ogrn_r;
  assign out_ch.out_blue  = oblu_r;

endmodule

FILE: rtl/core/iwb_lane.sv
`timescale 1ns / 1ps
// One color channel: running max, gain divider, gain multiply,
// normalizing divider and sRGB encode search. Depends on iwb_pkg.
module iwb_lane import iwb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  iwb_cmd_t          cmd,
  input  logic [PIX_W-1:0]  pix,
  input  logic [ILL_W-1:0]  illum,
  input  logic [PROD_W-1:0] m,
  output logic [PROD_W-1:0] prod,
  output logic [PIX_W-1:0]  code
);

  logic [PIX_W-1:0]  max_r, max_nxt, pix_r, lin_addr, cand;
  logic [ILL_W-1:0]  dvs_r, grem_r, grem_nxt;
  logic [ILL_W:0]    grem_sh;
  logic              gbit, nbit, sat_r;
  logic [GAIN_W-1:0] gain_r;
  logic [PROD_W-1:0] prod_r, nrem_r, nrem_nxt;
  logic [PROD_W:0]   r2;
  logic [IDX_W-1:0]  q_r, idx;
  logic [IDX_W:0]    idx_sum;
  logic [THR_W-1:0]  x;
  logic [LIN_W-1:0]  lin_q;
  logic [PIX_W-1:0]  code_r;

  assign max_nxt = (cmd.clr || pix > max_r) ? pix : max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= '0;
    end else if (cmd.meas) begin
      max_r <= max_nxt;
    end
  end

  // restoring divide of the constant, quotient shifts in over the dividend
  assign grem_sh  = {grem_r, gain_r[GAIN_W-1]};
  assign gbit     = grem_sh >= {1'b0, dvs_r};
  assign grem_nxt = gbit ? ILL_W'(grem_sh - {1'b0, dvs_r}) : grem_sh[ILL_W-1:0];

  assign lin_addr = cmd.mul_max ? max_r : pix_r;
  assign lin_q    = LIN_ROM[lin_addr];

  assign r2       = {nrem_r, 1'b0};
  assign nbit     = r2 >= {1'b0, m};
  assign nrem_nxt = nbit ? PROD_W'(r2 - {1'b0, m}) : r2[PROD_W-1:0];

  assign idx_sum = {1'b0, q_r} + (IDX_W + 1)'(1);
  assign idx     = sat_r ? IDX_W'(1 << OUT_LUT_BITS) : idx_sum[IDX_W:1];
  assign x       = {idx, (FRAC - OUT_LUT_BITS)'(0)};
  assign cand    = code_r | (PIX_W'(1) << cmd.enc_bit);

  always_ff @(posedge clk) begin
    if (cmd.load) pix_r <= pix;
    if (cmd.gain_ld) begin
      grem_r <= '0;
      gain_r <= INV_SQRT3_Q32;
      dvs_r  <= (illum == '0) ? ILL_W'(1) : illum;
    end else if (cmd.gain_step) begin
      grem_r <= grem_nxt;
      gain_r <= {gain_r[GAIN_W-2:0], gbit};
    end
    if (cmd.mul_max || cmd.mul_pix) begin
      prod_r <= {{GAIN_W{1'b0}}, lin_q} * {{LIN_W{1'b0}}, gain_r};
    end
    if (cmd.norm_ld) begin
      nrem_r <= prod_r;
      q_r    <= '0;
      sat_r  <= prod_r >= m;
      code_r <= '0;
    end else if (cmd.norm_step) begin
      nrem_r <= nrem_nxt;
      q_r    <= {q_r[IDX_W-2:0], nbit};
    end else if (cmd.enc_step) begin
      if (THR_ROM[cand] <= x) code_r <= cand;
    end
  end

  assign prod = prod_r;
  assign code = code_r;

endmodule
